[hw/rtl/free_list_fit_allocator_macros.svh]
// ----------------------------------------------------------------------------
// free_list_fit_allocator_macros
// assertion macros for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_FIT_ALLOCATOR_MACROS_SVH
`define FREE_LIST_FIT_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

`define FLA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fla assertion failed");

`define FLA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fla assertion failed");

`else

`define FLA_ASSERT(lbl, clk, rst, prop)
`define FLA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[hw/rtl/fla_pkg.sv]
// ----------------------------------------------------------------------------
// fla_pkg
// types, codes and sizes shared by the free list allocator
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_BITS     = 16;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);

  localparam logic [ADDR_BITS-1:0] ADDR_MASK = {ADDR_BITS{1'b1}};

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOFIT = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [1:0] CFG_FIT_MODE  = 2'd0;
  localparam logic [1:0] CFG_POOL_BASE = 2'd1;
  localparam logic [1:0] CFG_POOL_SIZE = 2'd2;

  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_INSERT = 3'd4;
  localparam logic [2:0] OP_MERGE  = 3'd5;

  typedef struct packed {
    logic                 func;
    logic                 mode;
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS-1:0] len;
    logic [CNT_BITS-1:0]  count;
  } req_t;

  typedef struct packed {
    logic [2:0]           op;
    logic [IDX_BITS-1:0]  idx;
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] len;
  } upd_t;

  typedef struct packed {
    logic                 found;
    logic [IDX_BITS-1:0]  bidx;
    logic [ADDR_BITS-1:0] bstart;
    logic [ADDR_BITS-1:0] blen;
    logic                 hit;
    logic [IDX_BITS-1:0]  hidx;
    logic [ADDR_BITS-1:0] ustart;
    logic [ADDR_BITS-1:0] ulen;
    logic                 have_prev;
    logic [ADDR_BITS-1:0] pstart;
    logic [ADDR_BITS-1:0] plen;
  } token_t;

endpackage

[hw/rtl/fla_cell.sv]
// ----------------------------------------------------------------------------
// fla_cell
// one table entry with its slice of the search pipeline
// ----------------------------------------------------------------------------
module fla_cell
  import fla_pkg::*;
(
  input  logic                 clk,
  input  logic [IDX_BITS-1:0]  idx,
  input  req_t                 req,
  input  upd_t                 upd,
  input  token_t               tok_in,
  input  logic [ADDR_BITS-1:0] prev_start,
  input  logic [ADDR_BITS-1:0] prev_len,
  input  logic [ADDR_BITS-1:0] next_start,
  input  logic [ADDR_BITS-1:0] next_len,
  output logic [ADDR_BITS-1:0] start,
  output logic [ADDR_BITS-1:0] len,
  output token_t               tok_out
);

  logic   valid;
  logic   take;
  token_t tok_next;

  assign valid = {1'b0, idx} < req.count;

  always_comb begin
    tok_next = tok_in;
    take     = 1'b0;
    if (valid) begin
      if (req.func == FUNC_ALLOC) begin
        if (req.mode == 1'b0) begin
          take = (len >= req.len) && (!tok_in.found || len < tok_in.blen);
        end else begin
          take = !tok_in.found || len > tok_in.blen;
        end
        if (take) begin
          tok_next.found  = 1'b1;
          tok_next.bidx   = idx;
          tok_next.bstart = start;
          tok_next.blen   = len;
        end
      end else if (!tok_in.hit) begin
        if (start > req.addr) begin
          tok_next.hit    = 1'b1;
          tok_next.hidx   = idx;
          tok_next.ustart = start;
          tok_next.ulen   = len;
        end else begin
          tok_next.have_prev = 1'b1;
          tok_next.pstart    = start;
          tok_next.plen      = len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

  always_ff @(posedge clk) begin
    unique case (upd.op)
      OP_LOAD: begin
        if (idx == '0) begin
          start <= upd.start;
          len   <= upd.len;
        end
      end
      OP_WRITE: begin
        if (idx == upd.idx) begin
          start <= upd.start;
          len   <= upd.len;
        end
      end
      OP_REMOVE: begin
        if (idx >= upd.idx) begin
          start <= next_start;
          len   <= next_len;
        end
      end
      OP_INSERT: begin
        if (idx > upd.idx) begin
          start <= prev_start;
          len   <= prev_len;
        end else if (idx == upd.idx) begin
          start <= upd.start;
          len   <= upd.len;
        end
      end
      OP_MERGE: begin
        if (idx > upd.idx) begin
          start <= next_start;
          len   <= next_len;
        end else if (idx == upd.idx) begin
          start <= upd.start;
          len   <= upd.len;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/free_list_fit_allocator.sv]
// ----------------------------------------------------------------------------
// free_list_fit_allocator
// best fit / worst fit allocator over an address-ordered free region table
// ----------------------------------------------------------------------------
// Each request walks its token along the row of table cells, one cell per
// cycle; then the apply step applies the update to all cells at once and
// loads the result register. The apply step waits while the previous result
// is still held at the output. One request is in flight at a time; a new
// word is accepted once the previous update is applied, even while its
// result still waits at the output. A configuration write reloads the
// table with the single pool region.
// ----------------------------------------------------------------------------
`include "free_list_fit_allocator_macros.svh"

module free_list_fit_allocator
  import fla_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [ADDR_BITS-1:0] span_addr,
  input  logic [ADDR_BITS-1:0] span_len,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_BITS-1:0] grant_addr,
  output logic [1:0]           status
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]           state;
  logic [IDX_BITS-1:0]  scan_cnt;
  logic [CNT_BITS-1:0]  count;
  logic                 fit_mode;
  logic [ADDR_BITS-1:0] pool_base;
  logic [ADDR_BITS-1:0] pool_size;
  logic                 req_func;
  logic [ADDR_BITS-1:0] req_addr;
  logic [ADDR_BITS-1:0] req_len;

  req_t                 req;
  upd_t                 upd;
  token_t               tok [TABLE_ENTRIES+1];
  logic [ADDR_BITS-1:0] cell_start [TABLE_ENTRIES];
  logic [ADDR_BITS-1:0] cell_len [TABLE_ENTRIES];

  logic                 in_fire;
  logic                 cfg_fire;
  logic                 cfg_load;
  logic                 out_free;
  logic                 apply_go;
  logic [ADDR_BITS:0]   in_sum;
  logic [ADDR_BITS-1:0] in_len_clip;
  logic                 new_mode;
  logic [ADDR_BITS-1:0] new_base;
  logic [ADDR_BITS-1:0] new_size;
  logic [ADDR_BITS:0]   pool_sum;
  logic [ADDR_BITS-1:0] pool_len;

  token_t               fin;
  upd_t                 dec_upd;
  logic [CNT_BITS-1:0]  dec_count;
  logic [1:0]           dec_status;
  logic [ADDR_BITS-1:0] dec_grant;
  logic [ADDR_BITS-1:0] nlen;
  logic [CNT_BITS-1:0]  ins_pos;
  logic [ADDR_BITS:0]   prev_end;
  logic [ADDR_BITS:0]   top;
  logic                 lower;
  logic                 upper;

  assign cfg_ready = (state == ST_IDLE);
  assign in_stall  = (state != ST_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_load  = cfg_fire && (cfg_index == CFG_FIT_MODE || cfg_index == CFG_POOL_BASE ||
                                  cfg_index == CFG_POOL_SIZE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign apply_go  = (state == ST_APPLY) && out_free;

  // release spans are clipped below the top address
  assign in_sum      = {1'b0, span_addr} + {1'b0, span_len};
  assign in_len_clip = (in_sum > {1'b0, ADDR_MASK}) ? (ADDR_MASK - span_addr) : span_len;

  always_comb begin
    new_mode = fit_mode;
    new_base = pool_base;
    new_size = pool_size;
    unique case (cfg_index)
      CFG_FIT_MODE:  new_mode = cfg_data[0];
      CFG_POOL_BASE: new_base = cfg_data;
      CFG_POOL_SIZE: new_size = cfg_data;
      default: begin
      end
    endcase
  end

  assign pool_sum = {1'b0, new_base} + {1'b0, new_size};
  assign pool_len = (pool_sum > {1'b0, ADDR_MASK}) ? (ADDR_MASK - new_base) : new_size;

  assign req.func  = req_func;
  assign req.mode  = fit_mode;
  assign req.addr  = req_addr;
  assign req.len   = req_len;
  assign req.count = count;

  assign tok[0] = '0;

  genvar k;
  generate
    for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      logic [ADDR_BITS-1:0] p_start;
      logic [ADDR_BITS-1:0] p_len;
      logic [ADDR_BITS-1:0] n_start;
      logic [ADDR_BITS-1:0] n_len;
      if (k == 0) begin : g_first
        assign p_start = '0;
        assign p_len   = '0;
      end else begin : g_mid
        assign p_start = cell_start[k-1];
        assign p_len   = cell_len[k-1];
      end
      if (k == TABLE_ENTRIES - 1) begin : g_last
        assign n_start = '0;
        assign n_len   = '0;
      end else begin : g_more
        assign n_start = cell_start[k+1];
        assign n_len   = cell_len[k+1];
      end
      fla_cell u_cell (
        .clk        (clk),
        .idx        (IDX_BITS'(k)),
        .req        (req),
        .upd        (upd),
        .tok_in     (tok[k]),
        .prev_start (p_start),
        .prev_len   (p_len),
        .next_start (n_start),
        .next_len   (n_len),
        .start      (cell_start[k]),
        .len        (cell_len[k]),
        .tok_out    (tok[k+1])
      );
    end
  endgenerate

  assign fin = tok[TABLE_ENTRIES];

  always_comb begin
    dec_upd       = '0;
    dec_upd.op    = OP_NONE;
    dec_count     = count;
    dec_status    = STATUS_OK;
    dec_grant     = '0;
    nlen          = fin.blen - req_len;
    ins_pos       = fin.hit ? {1'b0, fin.hidx} : count;
    prev_end      = {1'b0, fin.pstart} + {1'b0, fin.plen};
    top           = {1'b0, req_addr} + {1'b0, req_len};
    lower         = fin.have_prev && (prev_end == {1'b0, req_addr});
    upper         = fin.hit && (top == {1'b0, fin.ustart});
    if (req_func == FUNC_ALLOC) begin
      if (!fin.found || fin.blen < req_len) begin
        dec_status = STATUS_NOFIT;
      end else begin
        dec_grant     = fin.bstart;
        dec_upd.idx   = fin.bidx;
        dec_upd.start = fin.bstart + req_len;
        dec_upd.len   = nlen;
        if (nlen == '0) begin
          dec_upd.op = OP_REMOVE;
          dec_count  = count - 1'b1;
        end else begin
          dec_upd.op = OP_WRITE;
        end
      end
    end else if (req_len != '0) begin
      if (lower && upper) begin
        dec_upd.op    = OP_MERGE;
        dec_upd.idx   = IDX_BITS'(ins_pos - 1'b1);
        dec_upd.start = fin.pstart;
        dec_upd.len   = fin.ustart + fin.ulen - fin.pstart;
        dec_count     = count - 1'b1;
      end else if (lower) begin
        dec_upd.op    = OP_WRITE;
        dec_upd.idx   = IDX_BITS'(ins_pos - 1'b1);
        dec_upd.start = fin.pstart;
        dec_upd.len   = top[ADDR_BITS-1:0] - fin.pstart;
      end else if (upper) begin
        dec_upd.op    = OP_WRITE;
        dec_upd.idx   = fin.hidx;
        dec_upd.start = req_addr;
        dec_upd.len   = fin.ulen + req_len;
      end else if (count == CNT_BITS'(TABLE_ENTRIES)) begin
        dec_status = STATUS_FULL;
      end else begin
        dec_upd.op    = OP_INSERT;
        dec_upd.idx   = IDX_BITS'(ins_pos);
        dec_upd.start = req_addr;
        dec_upd.len   = req_len;
        dec_count     = count + 1'b1;
      end
    end
  end

  always_comb begin
    upd    = '0;
    upd.op = OP_NONE;
    if (apply_go) begin
      upd = dec_upd;
    end else if (cfg_load) begin
      upd.op    = OP_LOAD;
      upd.idx   = '0;
      upd.start = new_base;
      upd.len   = pool_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_cnt  <= '0;
      count     <= '0;
      fit_mode  <= 1'b0;
      pool_base <= '0;
      pool_size <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !apply_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cfg_load) begin
            fit_mode  <= new_mode;
            pool_base <= new_base;
            pool_size <= new_size;
            count     <= (pool_len != '0) ? CNT_BITS'(1) : '0;
          end
          if (in_fire) begin
            state    <= ST_SCAN;
            scan_cnt <= '0;
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == IDX_BITS'(TABLE_ENTRIES - 1)) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (apply_go) begin
            count     <= dec_count;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_func <= func;
      req_addr <= span_addr;
      req_len  <= (func == FUNC_RELEASE) ? in_len_clip : span_len;
    end
    if (apply_go) begin
      grant_addr <= dec_grant;
      status     <= dec_status;
    end
  end

  `FLA_ASSERT(a_count_max, clk, rst, count <= CNT_BITS'(TABLE_ENTRIES))
  `FLA_ASSERT(a_out_from_apply, clk, rst, $rose(out_valid) |-> $past(state) == ST_APPLY)
  `FLA_ASSERT(a_full_only_full, clk, rst,
              ($rose(out_valid) && status == STATUS_FULL) |-> count == CNT_BITS'(TABLE_ENTRIES))
  `FLA_ASSERT(a_status_code, clk, rst, out_valid |-> status <= STATUS_FULL)

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// regression for the free list fit allocator: a predictor keeps its own
// region table, every result is compared against it, under random idling,
// a long output hold-off and several pool / fit settings
// ----------------------------------------------------------------------------
module tb_top;
  import fla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 func;
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS-1:0] len;
  } span_req_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] grant;
    logic [1:0]           status;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = CFG_FIT_MODE;
  logic [15:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 func = FUNC_ALLOC;
  logic [ADDR_BITS-1:0] span_addr = '0;
  logic [ADDR_BITS-1:0] span_len = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ADDR_BITS-1:0] grant_addr;
  logic [1:0]           status;

  free_list_fit_allocator DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int unsigned free_start[TABLE_ENTRIES];
  int unsigned free_len[TABLE_ENTRIES];
  int unsigned free_count;
  int unsigned mode_q, base_q, size_q;

  span_req_t pending_words[$];
  grant_t    expected_grants[$];
  int        errors = 0;
  int        accepted = 0;
  int        checked = 0;
  int        full_hits = 0;
  int        nofit_hits = 0;
  bit        calm = 1'b0;
  bit        hold_out = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;

  function automatic int unsigned clip(int unsigned s, int unsigned l);
    if (s + l > 65535) return 65535 - s;
    return l;
  endfunction

  function automatic void load_table();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      free_start[i] = 0;
      free_len[i] = 0;
    end
    free_start[0] = base_q;
    free_len[0] = clip(base_q, size_q);
    free_count = (free_len[0] != 0) ? 1 : 0;
  endfunction

  function automatic void drop_entry(int unsigned i);
    for (int unsigned k = i; k + 1 < free_count; k++) begin
      free_start[k] = free_start[k+1];
      free_len[k] = free_len[k+1];
    end
    free_count--;
    free_start[free_count] = 0;
    free_len[free_count] = 0;
  endfunction

  function automatic grant_t serve_span(span_req_t w);
    grant_t r;
    int unsigned pick, i, k, len, top;
    bit found, lo, hi;
    r.grant = '0;
    r.status = STATUS_OK;
    pick = 0;
    found = 0;
    len = w.len;
    if (w.func == FUNC_ALLOC) begin
      for (i = 0; i < free_count; i++) begin
        if (mode_q == 0) begin
          if (free_len[i] >= len && (!found || free_len[i] < free_len[pick])) begin
            pick = i;
            found = 1;
          end
        end else if (!found || free_len[i] > free_len[pick]) begin
          pick = i;
          found = 1;
        end
      end
      if (!found || free_len[pick] < len) begin
        r.status = STATUS_NOFIT;
        return r;
      end
      r.grant = 16'(free_start[pick]);
      free_start[pick] = (free_start[pick] + len) & 16'hFFFF;
      free_len[pick] -= len;
      if (free_len[pick] == 0) drop_entry(pick);
      return r;
    end
    len = clip(w.addr, len);
    if (len == 0) return r;
    top = w.addr + len;
    for (i = 0; i < free_count && free_start[i] <= w.addr; i++) ;
    lo = i > 0 && free_start[i-1] + free_len[i-1] == w.addr;
    hi = i < free_count && top == free_start[i];
    if (lo) begin
      if (hi) begin
        free_len[i-1] = free_start[i] + free_len[i] - free_start[i-1];
        drop_entry(i);
      end else begin
        free_len[i-1] = top - free_start[i-1];
      end
      return r;
    end
    if (hi) begin
      free_len[i] += len;
      free_start[i] = w.addr;
      return r;
    end
    if (free_count >= TABLE_ENTRIES) begin
      r.status = STATUS_FULL;
      return r;
    end
    for (k = free_count; k > i; k--) begin
      free_start[k] = free_start[k-1];
      free_len[k] = free_len[k-1];
    end
    free_start[i] = w.addr;
    free_len[i] = len;
    free_count++;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_grants.push_back(serve_span({func, span_addr, span_len}));
        accepted++;
      end
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        {func, span_addr, span_len} <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected word grant=%0d status=%0d", $time, grant_addr, status);
          errors++;
        end else begin
          exp_g = expected_grants.pop_front();
          checked++;
          if (exp_g.status == STATUS_FULL) full_hits++;
          if (exp_g.status == STATUS_NOFIT) nofit_hits++;
          if (grant_addr !== exp_g.grant) begin
            $display("%0t: grant_addr expected %0d actual %0d", $time, exp_g.grant, grant_addr);
            errors++;
          end
          if (status !== exp_g.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_g.status, status);
            errors++;
          end
        end
      end
      if (hold_out) begin
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val[15:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FIT_MODE) mode_q = val & 1;
    else if (idx == CFG_POOL_BASE) base_q = val & 16'hFFFF;
    else size_q = val & 16'hFFFF;
    load_table();
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_grants.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic void add_word(logic f, int unsigned a, int unsigned l);
    pending_words.push_back({f, a[15:0], l[15:0]});
  endfunction

  // random phase: mostly well-formed alloc/free pairs
  task automatic random_phase(int n);
    int unsigned a, l;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // allocate a mostly small random length
          l = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 300);
          add_word(FUNC_ALLOC, $urandom, l);
        end
        4, 5, 6, 7, 8: begin
          // release a hole inside the pool, often leaving gaps
          a = (base_q + $urandom_range(0, size_q)) & 16'hFFFF;
          l = $urandom_range(0, 40);
          add_word(FUNC_RELEASE, a, l);
        end
        default: add_word(1'($urandom), $urandom, $urandom);
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    mode_q = 0;
    base_q = 0;
    size_q = 0;
    load_table();
    @(posedge clk);

    // directed: empty table, then a full pool and edge lengths
    add_word(FUNC_ALLOC, 0, 0);
    add_word(FUNC_ALLOC, 16'hFFFF, 1);
    add_word(FUNC_RELEASE, 100, 0);
    add_word(FUNC_RELEASE, 16'hFFF0, 16'hFFFF);
    add_word(FUNC_ALLOC, 0, 16'hFFFF);
    add_word(FUNC_ALLOC, 0, 15);
    drain();
    write_reg(CFG_POOL_BASE, 16'hFFFF);
    write_reg(CFG_POOL_SIZE, 16'hFFFF);
    add_word(FUNC_ALLOC, 0, 0);
    drain();
    write_reg(CFG_POOL_BASE, 1000);
    write_reg(CFG_POOL_SIZE, 1000);
    add_word(FUNC_ALLOC, 0, 100);
    add_word(FUNC_ALLOC, 0, 200);
    add_word(FUNC_ALLOC, 0, 300);
    add_word(FUNC_RELEASE, 1000, 100);
    add_word(FUNC_RELEASE, 1300, 300);
    add_word(FUNC_ALLOC, 0, 50);
    add_word(FUNC_RELEASE, 1050, 50);
    add_word(FUNC_RELEASE, 1100, 200);
    add_word(FUNC_ALLOC, 0, 0);
    add_word(FUNC_ALLOC, 0, 2000);
    add_word(FUNC_RELEASE, 1000, 50);
    drain();
    write_reg(CFG_FIT_MODE, 1);
    add_word(FUNC_ALLOC, 0, 10);
    add_word(FUNC_ALLOC, 0, 0);
    drain();

    // fill the table with isolated holes until it reports full
    write_reg(CFG_POOL_BASE, 0);
    write_reg(CFG_POOL_SIZE, 10);
    for (int i = 0; i < 70; i++) add_word(FUNC_RELEASE, 100 + 4 * i, 2);
    // hold the output back while words pile up
    hold_out = 1'b1;
    repeat (400) @(posedge clk);
    hold_out = 1'b0;
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_FIT_MODE, p % 2);
      write_reg(CFG_POOL_BASE, (p == 5) ? 16'hFF00 : $urandom_range(0, 40000));
      write_reg(CFG_POOL_SIZE, (p == 5) ? 16'hFFFF : $urandom_range(100, 4000));
      if (p == 5) calm = 1'b1;
      random_phase(160);
      drain();
    end

    $display("covered %0d words, %0d checked, %0d no-fit and %0d table-full results",
             accepted, checked, nofit_hits, full_hits);
    $display("both fit modes, pools at address extremes, long output hold-off");
    if (errors == 0) begin
      $display("free_list_fit_allocator regression: pass");
    end else begin
      $display("free_list_fit_allocator regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout after %0d words", accepted);
    $display("free_list_fit_allocator regression: fail");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fla_pkg.sv
hw/rtl/fla_cell.sv
hw/rtl/free_list_fit_allocator.sv
tb/sv/tb_top.sv
